### rtl/core/rplb_pkg.sv
package rplb_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_INDEX,
    ST_WRITE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Command to the level store: read and write strobes plus the book they act on.
  typedef struct packed {
    logic rd;
    logic wr;
    logic side;
  } mem_cmd_t;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

endpackage

### rtl/core/ring_price_level_book_unit.sv
// Channel   Direction  Payload
// s_axis    in         tuser: side; tdata: price_ticks, quantity
// m_axis    out        tuser: side_out, book_nonempty, dropped; tdata: best_price, best_quantity
//
// An ordinary update runs from transfer to the next transfer through head read, index
// and slot read, write-back, result; each step waits on the registered read of the level store.
// An empty-book update skips index and write-back; one outside the window skips write-back.
// Removing the best level adds a scan step per slot walked, at most RING_SIZE - 1 slots.
// After reset the quantity stores are swept to zero, slot by slot, with s_axis_tready low.
// A result waiting on m_axis holds the block in its result step; the next update is taken there.
module ring_price_level_book_unit #(
  parameter int RING_SIZE   = 1024,
  parameter int PRICE_WIDTH = 32,
  parameter int QTY_WIDTH   = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // price_ticks, quantity (zero fill to whole bytes)
  input  logic [((PRICE_WIDTH+QTY_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // side
  input  logic [0:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // best_price, best_quantity (zero fill to whole bytes)
  output logic [((PRICE_WIDTH+QTY_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // side_out, book_nonempty, dropped
  output logic [2:0] m_axis_tuser
);
  import rplb_pkg::*;

  localparam int AW = $clog2(RING_SIZE);
  localparam int CW = $clog2(RING_SIZE + 1);
  localparam int MW = (PRICE_WIDTH > AW + 1) ? PRICE_WIDTH : AW + 1;
  localparam int DW = ((PRICE_WIDTH + QTY_WIDTH + 7) / 8) * 8;

  state_t state, state_next;

  logic [AW-1:0] head  [2];
  logic [CW-1:0] count [2];

  logic                   side_q, worse_q;
  logic [PRICE_WIDTH-1:0] price_q, hp_q, mag_q;
  logic [QTY_WIDTH-1:0]   qty_q, hq_q;
  logic [AW-1:0]          idx_q, scan_q;

  logic [PRICE_WIDTH-1:0] res_price, out_price;
  logic [QTY_WIDTH-1:0]   res_qty, out_qty;
  logic                   res_nonempty, res_dropped;
  logic                   out_side, out_nonempty, out_dropped;

  logic                   in_side;
  logic [PRICE_WIDTH-1:0] in_price;
  logic [QTY_WIDTH-1:0]   in_qty;
  logic                   in_ready, accept, out_free;

  mem_cmd_t               cmd;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [PRICE_WIDTH-1:0] wr_price, rd_price;
  logic [QTY_WIDTH-1:0]   wr_qty, rd_qty;
  logic                   clearing;

  logic [AW-1:0]          h_cur;
  logic                   cnt_zero, qty_nz, price_ge, drop;
  logic [MW-1:0]          mag_ext;
  logic [AW:0]            sum_fwd, sum_back, sum_raw;
  logic [AW-1:0]          idx;
  logic [CW-1:0]          cnt_new;
  logic                   better, walk, found;
  logic [AW-1:0]          scan_from, scan_next;

  assign in_side  = s_axis_tuser[0];
  assign in_price = s_axis_tdata[PRICE_WIDTH-1:0];
  assign in_qty   = s_axis_tdata[PRICE_WIDTH+QTY_WIDTH-1:PRICE_WIDTH];

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign in_ready = !clearing && ((state == ST_IDLE) || (state == ST_DONE && out_free));
  assign accept   = s_axis_tvalid && in_ready;
  assign s_axis_tready = in_ready;

  assign m_axis_tdata = DW'({out_qty, out_price});
  assign m_axis_tuser = {out_dropped, out_nonempty, out_side};

  // Datapath
  assign h_cur    = head[side_q];
  assign cnt_zero = (count[side_q] == '0);
  assign qty_nz   = (qty_q != '0);
  assign price_ge = (price_q >= rd_price);

  assign mag_ext  = MW'(mag_q);
  assign drop     = (mag_ext >= MW'(RING_SIZE));
  assign sum_fwd  = {1'b0, h_cur} + {1'b0, mag_q[AW-1:0]};
  assign sum_back = {1'b0, h_cur} + (AW+1)'(RING_SIZE) - {1'b0, mag_q[AW-1:0]};
  assign sum_raw  = worse_q ? sum_fwd : sum_back;
  assign idx      = (sum_raw >= (AW+1)'(RING_SIZE)) ? AW'(sum_raw - (AW+1)'(RING_SIZE))
                                                    : sum_raw[AW-1:0];

  assign cnt_new  = count[side_q] - CW'(rd_qty != '0) + CW'(qty_nz);
  assign better   = qty_nz && !worse_q && (mag_q != '0);
  assign walk     = !qty_nz && (idx_q == h_cur) && (cnt_new != '0);
  assign found    = (rd_qty != '0);

  assign scan_from = (state == ST_WRITE) ? h_cur : scan_q;
  assign scan_next = (scan_from == AW'(RING_SIZE - 1)) ? '0 : scan_from + 1'b1;

  rplb_level_store #(
    .RING_SIZE  (RING_SIZE),
    .PRICE_WIDTH(PRICE_WIDTH),
    .QTY_WIDTH  (QTY_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_price(wr_price),
    .wr_qty  (wr_qty),
    .rd_price(rd_price),
    .rd_qty  (rd_qty),
    .clearing(clearing)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_HEAD;
      end
      ST_HEAD: begin
        state_next = cnt_zero ? ST_DONE : ST_INDEX;
      end
      ST_INDEX: begin
        state_next = drop ? ST_DONE : ST_WRITE;
      end
      ST_WRITE: begin
        state_next = walk ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (found) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (accept) begin
          state_next = ST_HEAD;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.side = side_q;
    rd_addr  = '0;
    wr_addr  = '0;
    wr_price = price_q;
    wr_qty   = qty_q;
    unique case (state)
      ST_IDLE, ST_DONE: begin
        cmd.rd   = accept;
        cmd.side = in_side;
        rd_addr  = head[in_side];
      end
      ST_HEAD: begin
        cmd.wr = cnt_zero;
      end
      ST_INDEX: begin
        cmd.rd  = !drop;
        rd_addr = idx;
      end
      ST_WRITE: begin
        cmd.wr  = 1'b1;
        wr_addr = idx_q;
        cmd.rd  = walk;
        rd_addr = scan_next;
      end
      ST_SCAN: begin
        cmd.rd  = !found;
        rd_addr = scan_next;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      head          <= '{default: '0};
      count         <= '{default: '0};
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_HEAD: begin
          if (cnt_zero) begin
            head[side_q]  <= '0;
            count[side_q] <= CW'(qty_nz);
          end
        end
        ST_WRITE: begin
          count[side_q] <= cnt_new;
          if (better) head[side_q] <= idx_q;
        end
        ST_SCAN: begin
          if (found) head[side_q] <= scan_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      side_q  <= in_side;
      price_q <= in_price;
      qty_q   <= in_qty;
    end
    unique case (state)
      ST_HEAD: begin
        hp_q    <= rd_price;
        hq_q    <= rd_qty;
        mag_q   <= price_ge ? price_q - rd_price : rd_price - price_q;
        worse_q <= price_ge ? side_q : !side_q;
        // Empty book: the update lands in slot 0 without a window check.
        res_price    <= qty_nz ? price_q : '0;
        res_qty      <= qty_q;
        res_nonempty <= qty_nz;
        res_dropped  <= 1'b0;
      end
      ST_INDEX: begin
        idx_q        <= idx;
        res_price    <= hp_q;
        res_qty      <= hq_q;
        res_nonempty <= 1'b1;
        res_dropped  <= 1'b1;
      end
      ST_WRITE: begin
        scan_q      <= scan_next;
        res_dropped <= 1'b0;
        if (cnt_new == '0) begin
          res_price    <= '0;
          res_qty      <= '0;
          res_nonempty <= 1'b0;
        end else if (better || idx_q == h_cur) begin
          res_price    <= price_q;
          res_qty      <= qty_q;
          res_nonempty <= 1'b1;
        end else begin
          res_price    <= hp_q;
          res_qty      <= hq_q;
          res_nonempty <= 1'b1;
        end
      end
      ST_SCAN: begin
        // Advance until a nonzero level comes back from the store.
        if (!found) scan_q <= scan_next;
        res_price    <= rd_price;
        res_qty      <= rd_qty;
        res_nonempty <= 1'b1;
        res_dropped  <= 1'b0;
      end
      ST_DONE: begin
        if (out_free) begin
          out_side     <= side_q;
          out_price    <= res_price;
          out_qty      <= res_qty;
          out_nonempty <= res_nonempty;
          out_dropped  <= res_dropped;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/rplb_level_store.sv
module rplb_level_store #(
  parameter int RING_SIZE   = 1024,
  parameter int PRICE_WIDTH = 32,
  parameter int QTY_WIDTH   = 32,
  localparam int AW         = $clog2(RING_SIZE)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rplb_pkg::mem_cmd_t     cmd,
  input  logic [AW-1:0]          rd_addr,
  input  logic [AW-1:0]          wr_addr,
  input  logic [PRICE_WIDTH-1:0] wr_price,
  input  logic [QTY_WIDTH-1:0]   wr_qty,
  output logic [PRICE_WIDTH-1:0] rd_price,
  output logic [QTY_WIDTH-1:0]   rd_qty,
  output logic                   clearing
);
  import rplb_pkg::*;

  logic [PRICE_WIDTH-1:0] bid_price [RING_SIZE];
  logic [PRICE_WIDTH-1:0] ask_price [RING_SIZE];
  logic [QTY_WIDTH-1:0]   bid_qty   [RING_SIZE];
  logic [QTY_WIDTH-1:0]   ask_qty   [RING_SIZE];

  logic [AW-1:0] clr_addr;
  logic          wr_live;

  assign wr_live = cmd.wr && !clearing;

  // Sweep both quantity stores to zero after reset, one slot per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(RING_SIZE - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_live) begin
      if (cmd.side == SIDE_ASK) begin
        ask_price[wr_addr] <= wr_price;
      end else begin
        bid_price[wr_addr] <= wr_price;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      bid_qty[clr_addr] <= '0;
      ask_qty[clr_addr] <= '0;
    end else if (cmd.wr) begin
      if (cmd.side == SIDE_ASK) begin
        ask_qty[wr_addr] <= wr_qty;
      end else begin
        bid_qty[wr_addr] <= wr_qty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      if (cmd.side == SIDE_ASK) begin
        rd_price <= ask_price[rd_addr];
        rd_qty   <= ask_qty[rd_addr];
      end else begin
        rd_price <= bid_price[rd_addr];
        rd_qty   <= bid_qty[rd_addr];
      end
    end
  end

endmodule

### rtl/core/rplb_checker.sv
module rplb_checker #(
  parameter int PRICE_WIDTH = 32,
  parameter int QTY_WIDTH   = 32
) (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [((PRICE_WIDTH+QTY_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input logic [0:0] s_axis_tuser,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((PRICE_WIDTH+QTY_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser
);

  logic unused_in;
  assign unused_in = ^{s_axis_tdata, s_axis_tuser};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // One update is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("update taken while previous one still in work");

  // A drop only happens against a populated book, whose best level is reported.
  a_drop_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1])
    else $error("dropped update reported on empty book");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata == '0)
    else $error("empty book reports nonzero best level");

endmodule

bind ring_price_level_book_unit rplb_checker #(
  .PRICE_WIDTH(PRICE_WIDTH),
  .QTY_WIDTH  (QTY_WIDTH)
) u_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
